// ===== sv/tsrt_pkg.sv =====
// Shared types, constants and sequence-compare helpers for the TCP reassembly tracker.
`timescale 1ns / 1ps

package tsrt_pkg;

  localparam int MAX_PIECES_DEF = 16;

  localparam int SEQ_W = 32;
  localparam int LEN_W = 16;
  localparam int TIME_W = 32;
  localparam int CNTR_W = 32;
  localparam int TMO_W = 16;
  localparam int CAP_W = 21;
  localparam int QLIM_W = 5;
  localparam int DEPTH_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [TMO_W-1:0] HOLE_TIMEOUT_RST = 16'd1000;
  localparam logic [CAP_W-1:0] STREAM_CAP_RST = 21'h100000;
  localparam logic [QLIM_W-1:0] QUEUE_LIMIT_RST = 5'd16;
  localparam logic [LEN_W-1:0] LEN_SAT = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLE_TIMEOUT = 2'd0,
    CFG_STREAM_CAP = 2'd1,
    CFG_QUEUE_LIMIT = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REC_DELIVER = 2'd0,
    REC_SKIP = 2'd1,
    REC_FINAL = 2'd2
  } rec_kind_t;

  typedef enum logic [1:0] {
    FLOW_NEW = 2'd0,
    FLOW_EST = 2'd1,
    FLOW_CLOSED = 2'd2
  } flow_t;

  typedef enum logic [2:0] {
    OUT_QUEUED = 3'd0,
    OUT_DUP = 3'd1,
    OUT_FULL = 3'd2,
    OUT_CLOSED = 3'd3,
    OUT_SYN = 3'd4,
    OUT_RST = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    CMD_SYN,
    CMD_RST,
    CMD_DATA
  } cmd_kind_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_START,
    B_MRD,
    B_MEVAL,
    B_MCOPY,
    B_TAIL,
    B_DRD,
    B_DRAIN,
    B_FINAL
  } back_state_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic fin;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [SEQ_W-1:0] start;
    logic [LEN_W-1:0] len;
  } piece_t;

  typedef struct packed {
    rec_kind_t record_kind;
    logic [SEQ_W-1:0] range_start;
    logic [LEN_W-1:0] range_length;
    logic truncated;
    flow_t flow_state;
    logic [DEPTH_W-1:0] queue_depth;
    outcome_t outcome;
    logic [CNTR_W-1:0] retransmit_count;
    logic [CNTR_W-1:0] out_of_order_count;
    logic [CNTR_W-1:0] gap_flush_count;
    logic [CNTR_W-1:0] in_order_count;
    logic last_record;
  } rec_t;

  function automatic logic seq_lt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return d[SEQ_W-1];
  endfunction

  function automatic logic seq_le(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    return (a == b) || seq_lt(a, b);
  endfunction

endpackage

// ===== sv/tsrt_if.sv =====
// Channel interfaces for segment words, record words and configuration writes.
`timescale 1ns / 1ps

interface tsrt_seg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seq_number;
  logic [15:0] payload_length;
  logic        syn_flag;
  logic        rst_flag;
  logic        fin_flag;
  logic [31:0] now_ms;

  modport source (output valid, seq_number, payload_length, syn_flag, rst_flag, fin_flag,
                  now_ms, input ready);
  modport sink (input valid, seq_number, payload_length, syn_flag, rst_flag, fin_flag,
                now_ms, output ready);
endinterface

interface tsrt_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [31:0] range_start;
  logic [15:0] range_length;
  logic        truncated;
  logic [1:0]  flow_state;
  logic [4:0]  queue_depth;
  logic [2:0]  outcome;
  logic [31:0] retransmit_count;
  logic [31:0] out_of_order_count;
  logic [31:0] gap_flush_count;
  logic [31:0] in_order_count;
  logic        last_record;

  modport source (output valid, record_kind, range_start, range_length, truncated, flow_state,
                  queue_depth, outcome, retransmit_count, out_of_order_count,
                  gap_flush_count, in_order_count, last_record, input ready);
  modport sink (input valid, record_kind, range_start, range_length, truncated, flow_state,
                queue_depth, outcome, retransmit_count, out_of_order_count,
                gap_flush_count, in_order_count, last_record, output ready);
endinterface

interface tsrt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [20:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/tsrt_front.sv =====
// Front end: accepts segment words, classifies them and queues commands for the back end.
`timescale 1ns / 1ps

module tsrt_front
  import tsrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tsrt_seg_if.sink    in_seg,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  cmd_t       q_r [2];
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  cmd_t       dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec.seq = in_seg.seq_number;
    dec.len = in_seg.payload_length;
    dec.fin = in_seg.fin_flag;
    dec.now = in_seg.now_ms;
    if (in_seg.syn_flag) begin
      dec.kind = CMD_SYN;
    end else if (in_seg.rst_flag) begin
      dec.kind = CMD_RST;
    end else begin
      dec.kind = CMD_DATA;
    end
  end

  assign in_seg.ready = (fill_r != 2'd2);
  assign push = in_seg.valid && in_seg.ready;
  assign cmd_valid = (fill_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[0];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && fill_r == 2'd1) begin
        q_r[0] <= dec;
      end else begin
        q_r[0] <= q_r[1];
      end
      if (push && fill_r == 2'd2) begin
        q_r[1] <= dec;
      end
    end else if (push) begin
      if (fill_r == 2'd0) begin
        q_r[0] <= dec;
      end else begin
        q_r[1] <= dec;
      end
    end
  end

endmodule

// ===== sv/tsrt_back.sv =====
// Back end: runs the piece-table merge, the drain walk and the record output register.
`timescale 1ns / 1ps

module tsrt_back
  import tsrt_pkg::*;
#(
  parameter int MAX_PIECES = MAX_PIECES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  tsrt_cfg_if.sink    cfg_wr,
  tsrt_rec_if.source  out_rec
);

  localparam int AW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int CW = $clog2(MAX_PIECES + 1);
  localparam int LW = (CW > QLIM_W) ? CW : QLIM_W;

  back_state_t state_r, state_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [SEQ_W-1:0] exp_r, exp_nxt;
  logic expv_r, expv_nxt;
  flow_t conn_r, conn_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] base_r, base_nxt;
  logic bank_r, bank_nxt;
  logic hole_r, hole_nxt;
  logic [TIME_W-1:0] since_r, since_nxt;
  logic [CAP_W-1:0] bd_r, bd_nxt;
  logic [CNTR_W-1:0] retx_r, retx_nxt, ooo_r, ooo_nxt, gap_r, gap_nxt, inord_r, inord_nxt;
  outcome_t outcome_r, outcome_nxt;
  logic [TMO_W-1:0] tmo_r, tmo_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [QLIM_W-1:0] qlim_r, qlim_nxt;
  logic [SEQ_W-1:0] cur_r, cur_nxt, end_r, end_nxt;
  logic done_r, done_nxt;
  logic [CW-1:0] idx_r, idx_nxt, wpos_r, wpos_nxt, ncnt_r, ncnt_nxt;
  logic out_valid_r, out_valid_nxt;
  rec_t out_rec_r, out_rec_nxt;

  piece_t m0 [MAX_PIECES];
  piece_t m1 [MAX_PIECES];
  piece_t rd0_r, rd1_r, rdata;
  logic rsel_r;
  logic we, wbank;
  logic [AW-1:0] waddr, raddr;
  piece_t wdata;
  logic [CW-1:0] raddr_full;

  logic free;
  logic [LW-1:0] lim;
  logic out_load;
  rec_kind_t em_kind;
  logic [SEQ_W-1:0] em_start;
  logic [LEN_W-1:0] em_len;
  logic em_trunc, em_last;

  logic [SEQ_W-1:0] seg_end, e_end, gap_end, gl, exp_eff, lead, skip, cur_gap;
  logic [CAP_W-1:0] room;
  logic [LEN_W-1:0] take;
  logic [TIME_W-1:0] waited;
  logic gap_hit;

  always_ff @(posedge clk) begin
    if (we && !wbank) begin
      m0[waddr] <= wdata;
    end
    rd0_r <= m0[raddr];
  end

  always_ff @(posedge clk) begin
    if (we && wbank) begin
      m1[waddr] <= wdata;
    end
    rd1_r <= m1[raddr];
    rsel_r <= bank_r;
  end

  assign rdata = rsel_r ? rd1_r : rd0_r;
  assign raddr_full = (state_r == B_MRD || state_r == B_MEVAL || state_r == B_MCOPY) ?
                      base_r + idx_r : base_r;
  assign raddr = raddr_full[AW-1:0];

  assign free = !out_valid_r || out_rec.ready;
  assign lim = (LW'(qlim_r) > LW'(MAX_PIECES)) ? LW'(MAX_PIECES) : LW'(qlim_r);
  assign cfg_wr.ready = 1'b1;

  assign seg_end = cmd_r.seq + SEQ_W'(cmd_r.len);
  assign e_end = rdata.start + SEQ_W'(rdata.len);
  assign gap_end = seq_lt(end_r, rdata.start) ? end_r : rdata.start;
  assign gl = gap_end - cur_r;
  assign gap_hit = !done_r && seq_lt(cur_r, rdata.start) && (gl != '0);
  assign cur_gap = cur_r + gl;
  assign exp_eff = expv_r ? exp_r : rdata.start;
  assign lead = rdata.start - exp_eff;
  assign skip = exp_eff - rdata.start;
  assign room = (bd_r >= cap_r) ? '0 : cap_r - bd_r;
  assign take = (CAP_W'(rdata.len) < room) ? rdata.len : room[LEN_W-1:0];
  assign waited = cmd_r.now - since_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    exp_nxt = exp_r;
    expv_nxt = expv_r;
    conn_nxt = conn_r;
    cnt_nxt = cnt_r;
    base_nxt = base_r;
    bank_nxt = bank_r;
    hole_nxt = hole_r;
    since_nxt = since_r;
    bd_nxt = bd_r;
    retx_nxt = retx_r;
    ooo_nxt = ooo_r;
    gap_nxt = gap_r;
    inord_nxt = inord_r;
    outcome_nxt = outcome_r;
    tmo_nxt = tmo_r;
    cap_nxt = cap_r;
    qlim_nxt = qlim_r;
    cur_nxt = cur_r;
    end_nxt = end_r;
    done_nxt = done_r;
    idx_nxt = idx_r;
    wpos_nxt = wpos_r;
    ncnt_nxt = ncnt_r;
    cmd_ready = 1'b0;
    we = 1'b0;
    wbank = !bank_r;
    waddr = wpos_r[AW-1:0];
    wdata = rdata;
    out_load = 1'b0;
    em_kind = REC_FINAL;
    em_start = exp_r;
    em_len = '0;
    em_trunc = 1'b0;
    em_last = 1'b0;

    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_HOLE_TIMEOUT: tmo_nxt = cfg_wr.data[TMO_W-1:0];
        CFG_STREAM_CAP: cap_nxt = cfg_wr.data[CAP_W-1:0];
        CFG_QUEUE_LIMIT: qlim_nxt = cfg_wr.data[QLIM_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r) inside
      B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt = cmd;
          state_nxt = B_START;
        end
      end
      B_START: begin
        state_nxt = B_FINAL;
        unique case (cmd_r.kind)
          CMD_SYN: begin
            if (conn_r != FLOW_NEW || expv_r || bd_r != '0) begin
              cnt_nxt = '0;
              base_nxt = '0;
              bd_nxt = '0;
              retx_nxt = '0;
              ooo_nxt = '0;
              gap_nxt = '0;
              inord_nxt = '0;
            end
            exp_nxt = cmd_r.seq + 32'd1;
            expv_nxt = 1'b1;
            conn_nxt = FLOW_EST;
            hole_nxt = 1'b0;
            outcome_nxt = OUT_SYN;
          end
          CMD_RST: begin
            conn_nxt = FLOW_CLOSED;
            cnt_nxt = '0;
            base_nxt = '0;
            outcome_nxt = OUT_RST;
          end
          default: begin
            if (conn_r == FLOW_CLOSED) begin
              if (cmd_r.len != '0) begin
                retx_nxt = retx_r + 32'd1;
              end
              outcome_nxt = OUT_CLOSED;
            end else begin
              outcome_nxt = OUT_QUEUED;
              state_nxt = B_DRD;
              if (cmd_r.fin) begin
                conn_nxt = FLOW_CLOSED;
              end
              if (cmd_r.len != '0) begin
                if (expv_r && seq_le(seg_end, exp_r)) begin
                  retx_nxt = retx_r + 32'd1;
                  outcome_nxt = OUT_DUP;
                end else if (LW'(cnt_r) >= lim) begin
                  outcome_nxt = OUT_FULL;
                end else begin
                  cur_nxt = (expv_r && seq_lt(cmd_r.seq, exp_r)) ? exp_r : cmd_r.seq;
                  end_nxt = seg_end;
                  done_nxt = 1'b0;
                  idx_nxt = '0;
                  wpos_nxt = '0;
                  ncnt_nxt = cnt_r;
                  state_nxt = (cnt_r == '0) ? B_TAIL : B_MRD;
                end
                if (outcome_nxt != OUT_FULL && expv_r && cmd_r.seq != exp_r) begin
                  ooo_nxt = ooo_r + 32'd1;
                end
              end
            end
          end
        endcase
      end
      B_MRD: begin
        state_nxt = B_MEVAL;
      end
      B_MEVAL, B_MCOPY: begin
        if (state_r == B_MEVAL && gap_hit && LW'(ncnt_r) < lim) begin
          we = 1'b1;
          wdata.start = cur_r;
          wdata.len = gl[LEN_W-1:0];
          wpos_nxt = wpos_r + 1'b1;
          ncnt_nxt = ncnt_r + 1'b1;
          cur_nxt = cur_gap;
          if (!seq_lt(cur_gap, end_r)) begin
            done_nxt = 1'b1;
          end
          state_nxt = B_MCOPY;
        end else begin
          if (state_r == B_MEVAL && gap_hit) begin
            done_nxt = 1'b1;
          end else if (!done_r && seq_lt(cur_r, e_end)) begin
            cur_nxt = e_end;
            if (!seq_lt(e_end, end_r)) begin
              done_nxt = 1'b1;
            end
          end
          we = 1'b1;
          wpos_nxt = wpos_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
          state_nxt = (idx_r + 1'b1 == cnt_r) ? B_TAIL : B_MRD;
        end
      end
      B_TAIL: begin
        cnt_nxt = ncnt_r;
        if (!done_r && seq_lt(cur_r, end_r) && LW'(ncnt_r) < lim) begin
          we = 1'b1;
          wdata.start = cur_r;
          wdata.len = LEN_W'(end_r - cur_r);
          cnt_nxt = ncnt_r + 1'b1;
        end
        bank_nxt = !bank_r;
        base_nxt = '0;
        state_nxt = B_DRD;
      end
      B_DRD: begin
        state_nxt = (cnt_r == '0) ? B_FINAL : B_DRAIN;
      end
      B_DRAIN: begin
        if (free) begin
          state_nxt = B_DRD;
          expv_nxt = 1'b1;
          exp_nxt = exp_eff;
          if (lead == '0) begin
            bd_nxt = bd_r + CAP_W'(take);
            exp_nxt = exp_eff + SEQ_W'(rdata.len);
            inord_nxt = inord_r + 32'd1;
            base_nxt = base_r + 1'b1;
            cnt_nxt = cnt_r - 1'b1;
            hole_nxt = 1'b0;
            out_load = 1'b1;
            em_kind = REC_DELIVER;
            em_start = rdata.start;
            em_len = take;
            em_trunc = (take < rdata.len);
          end else if (lead[SEQ_W-1]) begin
            if (skip >= SEQ_W'(rdata.len)) begin
              base_nxt = base_r + 1'b1;
              cnt_nxt = cnt_r - 1'b1;
            end else begin
              we = 1'b1;
              wbank = bank_r;
              waddr = base_r[AW-1:0];
              wdata.start = rdata.start + skip;
              wdata.len = rdata.len - skip[LEN_W-1:0];
            end
          end else if (!hole_r) begin
            hole_nxt = 1'b1;
            since_nxt = cmd_r.now;
            state_nxt = B_FINAL;
          end else if (waited >= TIME_W'(tmo_r)) begin
            exp_nxt = rdata.start;
            gap_nxt = gap_r + 32'd1;
            hole_nxt = 1'b0;
            out_load = 1'b1;
            em_kind = REC_SKIP;
            em_start = exp_eff;
            em_len = (lead[SEQ_W-1:LEN_W] != '0) ? LEN_SAT : lead[LEN_W-1:0];
          end else begin
            state_nxt = B_FINAL;
          end
        end
      end
      B_FINAL: begin
        if (free) begin
          out_load = 1'b1;
          em_kind = REC_FINAL;
          em_start = exp_r;
          em_last = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    out_rec_nxt = out_rec_r;
    out_valid_nxt = out_valid_r && !out_rec.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_rec_nxt.record_kind = em_kind;
      out_rec_nxt.range_start = em_start;
      out_rec_nxt.range_length = em_len;
      out_rec_nxt.truncated = em_trunc;
      out_rec_nxt.flow_state = conn_nxt;
      out_rec_nxt.queue_depth = DEPTH_W'(cnt_nxt);
      out_rec_nxt.outcome = outcome_nxt;
      out_rec_nxt.retransmit_count = retx_nxt;
      out_rec_nxt.out_of_order_count = ooo_nxt;
      out_rec_nxt.gap_flush_count = gap_nxt;
      out_rec_nxt.in_order_count = inord_nxt;
      out_rec_nxt.last_record = em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      exp_r <= '0;
      expv_r <= 1'b0;
      conn_r <= FLOW_NEW;
      cnt_r <= '0;
      base_r <= '0;
      bank_r <= 1'b0;
      hole_r <= 1'b0;
      since_r <= '0;
      bd_r <= '0;
      retx_r <= '0;
      ooo_r <= '0;
      gap_r <= '0;
      inord_r <= '0;
      outcome_r <= OUT_QUEUED;
      tmo_r <= HOLE_TIMEOUT_RST;
      cap_r <= STREAM_CAP_RST;
      qlim_r <= QUEUE_LIMIT_RST;
      done_r <= 1'b0;
      idx_r <= '0;
      wpos_r <= '0;
      ncnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      exp_r <= exp_nxt;
      expv_r <= expv_nxt;
      conn_r <= conn_nxt;
      cnt_r <= cnt_nxt;
      base_r <= base_nxt;
      bank_r <= bank_nxt;
      hole_r <= hole_nxt;
      since_r <= since_nxt;
      bd_r <= bd_nxt;
      retx_r <= retx_nxt;
      ooo_r <= ooo_nxt;
      gap_r <= gap_nxt;
      inord_r <= inord_nxt;
      outcome_r <= outcome_nxt;
      tmo_r <= tmo_nxt;
      cap_r <= cap_nxt;
      qlim_r <= qlim_nxt;
      done_r <= done_nxt;
      idx_r <= idx_nxt;
      wpos_r <= wpos_nxt;
      ncnt_r <= ncnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    cur_r <= cur_nxt;
    end_r <= end_nxt;
    out_rec_r <= out_rec_nxt;
  end

  assign out_rec.valid = out_valid_r;
  assign out_rec.record_kind = out_rec_r.record_kind;
  assign out_rec.range_start = out_rec_r.range_start;
  assign out_rec.range_length = out_rec_r.range_length;
  assign out_rec.truncated = out_rec_r.truncated;
  assign out_rec.flow_state = out_rec_r.flow_state;
  assign out_rec.queue_depth = out_rec_r.queue_depth;
  assign out_rec.outcome = out_rec_r.outcome;
  assign out_rec.retransmit_count = out_rec_r.retransmit_count;
  assign out_rec.out_of_order_count = out_rec_r.out_of_order_count;
  assign out_rec.gap_flush_count = out_rec_r.gap_flush_count;
  assign out_rec.in_order_count = out_rec_r.in_order_count;
  assign out_rec.last_record = out_rec_r.last_record;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PIECES))
    else $error("Piece count exceeds the table depth.");

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, base_r} + {1'b0, cnt_r}) <= (CW + 1)'(MAX_PIECES))
    else $error("Live table window runs past the end of the bank.");

  a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rec_r.last_record |-> out_rec_r.record_kind == REC_FINAL)
    else $error("Last word of an event is not a status record.");

  a_hole_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    hole_r |-> expv_r)
    else $error("A gap is pending without an anchored next sequence.");

  a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_FINAL && free |=> state_r == B_IDLE)
    else $error("Status record sent but the event did not finish.");

endmodule

// ===== sv/tcp_segment_reassembly_tracker_top.sv =====
// Top level of the one-direction TCP segment reassembly tracker.
`timescale 1ns / 1ps

// Usage:
//   in_seg takes one segment word (sequence, payload length, SYN/RST/FIN, time in ms).
//   out_rec returns, for each segment, zero or more delivered-range and skipped-gap
//   words followed by exactly one status word with last_record set.
//   cfg_wr writes hole_timeout_ms (index 0), stream_cap_bytes (1) and queue_limit (2);
//   write it only while no segment is in flight.
// Queueing and throughput:
//   A two-word command queue decouples acceptance from execution, so in_seg keeps
//   taking words while the back end works or out_rec stalls, until the queue is full.
//   The back end handles one segment at a time. A SYN, RST or closed-context segment
//   needs the least work; a data segment adds a merge pass through the piece memory
//   that reads each held piece, plus a step per drained, skipped or trimmed head
//   piece. The work grows with the number of pieces held, set by the single read
//   port of the piece memory, which returns one entry per access.
// Reset:
//   rst_n clears the context, counters and queue; registers return to 1000 ms,
//   1048576 bytes and 16 pieces. No memory clearing pass is needed.
// Stall:
//   While out_rec is not ready the back end holds its word and waits to load another.

module tcp_segment_reassembly_tracker_top
  import tsrt_pkg::*;
#(
  parameter int MAX_PIECES = MAX_PIECES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tsrt_seg_if.sink    in_seg,
  tsrt_rec_if.source  out_rec,
  tsrt_cfg_if.sink    cfg_wr
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  tsrt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_seg    (in_seg),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tsrt_back #(
    .MAX_PIECES (MAX_PIECES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg_wr    (cfg_wr),
    .out_rec   (out_rec)
  );

endmodule
